FILE: sv/brd_pkg.sv
// Shared types and constants for the brace region detector.
// Depends on nothing; imported by brd_scan, brd_stack and the top module.
package brd_pkg;

  localparam int CHAR_W          = 16;
  localparam int LINE_BITS       = 20;
  localparam int EXCESS_W        = 20;
  localparam int STACK_DEPTH_DEF = 64;

  // Stream payload widths; the tdata fields are padded up to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  localparam logic [CHAR_W-1:0]   CH_OPEN   = 16'h007B;
  localparam logic [CHAR_W-1:0]   CH_CLOSE  = 16'h007D;
  localparam logic [CHAR_W-1:0]   CH_SLASH  = 16'h002F;
  localparam logic [CHAR_W-1:0]   CH_DQUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0]   CH_SQUOTE = 16'h0027;
  localparam logic [CHAR_W-1:0]   CH_BSLASH = 16'h005C;
  localparam logic [EXCESS_W-1:0] EXCESS_MAX = '1;

  // Brace events seen by the scanner outside strings and comments.
  typedef struct packed {
    logic is_open;
    logic is_close;
  } brd_event_t;

endpackage

FILE: sv/brd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the brace stack storage.
module brd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/brd_scan.sv
// Lexical scanner: tracks string and line comment state per character.
// Depends on brd_pkg; reports brace events that fall outside strings and comments.
module brd_scan
  import brd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              line_start,
  input  logic              doc_start,
  output brd_event_t        ev
);

  logic              in_quote, in_quote_next;
  logic [CHAR_W-1:0] quote_char, quote_char_next;
  logic              prev_backslash;
  logic              prev_slash, prev_slash_next;
  logic              in_comment, in_comment_next;

  logic q_cur, c_cur, bs_cur, sl_cur, is_quote, plain;

  always_comb begin
    // A new line drops any string or comment left open on the previous one.
    q_cur  = in_quote & ~(line_start | doc_start);
    c_cur  = in_comment & ~(line_start | doc_start);
    bs_cur = prev_backslash & ~(line_start | doc_start);
    sl_cur = prev_slash & ~(line_start | doc_start);

    is_quote        = (char_code == CH_DQUOTE) || (char_code == CH_SQUOTE);
    in_quote_next   = q_cur;
    quote_char_next = quote_char;
    in_comment_next = c_cur;
    prev_slash_next = sl_cur;
    plain           = 1'b0;

    if (c_cur) begin
      // Rest of the line is commented out.
    end else if (!q_cur && is_quote) begin
      in_quote_next   = 1'b1;
      quote_char_next = char_code;
      prev_slash_next = 1'b0;
    end else if (q_cur) begin
      if ((char_code == quote_char) && !bs_cur) begin
        in_quote_next = 1'b0;
      end
      prev_slash_next = 1'b0;
    end else if ((char_code == CH_SLASH) && sl_cur) begin
      in_comment_next = 1'b1;
      prev_slash_next = 1'b0;
    end else begin
      prev_slash_next = (char_code == CH_SLASH);
      plain           = 1'b1;
    end

    ev.is_open  = plain && (char_code == CH_OPEN);
    ev.is_close = plain && (char_code == CH_CLOSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote       <= 1'b0;
      quote_char     <= '0;
      prev_backslash <= 1'b0;
      prev_slash     <= 1'b0;
      in_comment     <= 1'b0;
    end else if (fire) begin
      in_quote       <= in_quote_next;
      quote_char     <= quote_char_next;
      prev_backslash <= (char_code == CH_BSLASH);
      prev_slash     <= prev_slash_next;
      in_comment     <= in_comment_next;
    end
  end

  // The character inputs only carry a real character while a step fires.
  property p_no_open_and_close;
    @(posedge clk) disable iff (rst) fire |-> !(ev.is_open && ev.is_close);
  endproperty
  a_no_open_and_close: assert property (p_no_open_and_close)
    else $error("scanner flagged open and close at once");

  property p_not_both_modes;
    @(posedge clk) disable iff (rst) !(in_quote && in_comment);
  endproperty
  a_not_both_modes: assert property (p_not_both_modes)
    else $error("string and comment state set together");

  property p_comment_quiet;
    @(posedge clk) disable iff (rst)
      (in_comment && !line_start && !doc_start) |-> !(ev.is_open || ev.is_close);
  endproperty
  a_comment_quiet: assert property (p_comment_quiet)
    else $error("brace event reported inside a comment");

endmodule

FILE: sv/brd_stack.sv
// Brace stack: depth counter, overflow counter, RAM storage and a top-of-stack bypass.
// Depends on brd_pkg and brd_ram; produces at most one region per character.
module brd_stack
  import brd_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  brd_event_t           ev,
  input  logic                 doc_start,
  input  logic [LINE_BITS-1:0] line,
  output logic                 res_valid,
  output logic [LINE_BITS-1:0] res_start
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  logic [CNT_W-1:0]     count, count_next, count_base, top_idx;
  logic [EXCESS_W-1:0]  excess, excess_next, excess_base;
  logic                 byp_valid;
  logic [LINE_BITS-1:0] byp_line;
  logic [LINE_BITS-1:0] ram_rdata, top_line;
  logic                 push, pop;
  logic [ADDR_W-1:0]    raddr;

  always_comb begin
    count_base  = doc_start ? '0 : count;
    excess_base = doc_start ? '0 : excess;
    count_next  = count_base;
    excess_next = excess_base;
    push        = 1'b0;
    pop         = 1'b0;
    // Freshly pushed entries are served from the bypass until the RAM read catches up.
    top_line    = byp_valid ? byp_line : ram_rdata;

    if (ev.is_open) begin
      if (count_base < CNT_FULL) begin
        push       = 1'b1;
        count_next = count_base + CNT_W'(1);
      end else if (excess_base != EXCESS_MAX) begin
        excess_next = excess_base + EXCESS_W'(1);
      end
    end else if (ev.is_close) begin
      if (excess_base != '0) begin
        excess_next = excess_base - EXCESS_W'(1);
      end else if (count_base != '0) begin
        pop        = 1'b1;
        count_next = count_base - CNT_W'(1);
      end
    end

    res_valid = pop && (line > top_line);
    res_start = top_line;

    // Prefetch whatever will be on top after this step.
    top_idx = (fire ? count_next : count) - CNT_W'(1);
    raddr   = top_idx[ADDR_W-1:0];
  end

  brd_ram #(
    .WIDTH(LINE_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (fire && push),
    .waddr(count_base[ADDR_W-1:0]),
    .wdata(line),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      excess    <= '0;
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= fire && push;
      if (fire) begin
        count  <= count_next;
        excess <= excess_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push) begin
      byp_line <= line;
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= CNT_FULL;
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("stack count beyond depth");

  property p_excess_only_when_full;
    @(posedge clk) disable iff (rst) (excess != '0) |-> (count == CNT_FULL);
  endproperty
  a_excess_only_when_full: assert property (p_excess_only_when_full)
    else $error("overflow count set while stack not full");

  property p_bypass_nonempty;
    @(posedge clk) disable iff (rst) byp_valid |-> (count != '0);
  endproperty
  a_bypass_nonempty: assert property (p_bypass_nonempty)
    else $error("bypass valid on an empty stack");

endmodule

FILE: sv/brace_region_detector_top.sv
// Brace region detector: one text character per transaction in, fold regions out.
// A character's region reaches m_tdata, with m_tvalid high, through the input
// register and then the result register; a pending result can hold it back.
// Throughput: one character per cycle while no region waits on a low m_tready; the
// single stack RAM port pair and its top-of-stack bypass let a push or pop follow any other operation directly.
// Reset (rst, synchronous, active high) empties the stack, clears string and
// comment state and drops any held transaction; stack RAM contents are not cleared.
module brace_region_detector_top
  import brd_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: [15:0] char_code, [35:16] line_number, [39:36] zero.
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: [0] line_start, [1] doc_start.
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: [19:0] region_start, [39:20] region_end.
  output logic [M_TDATA_W-1:0] m_tdata
);

  // Input register stage. A held character is processed as soon as the
  // output register has room, and it stays here until then.
  logic                 in_valid;
  logic [CHAR_W-1:0]    in_char;
  logic [LINE_BITS-1:0] in_line;
  logic                 in_line_start;
  logic                 in_doc_start;

  // The processing step fires when a character is held and the result register
  // is free or being emptied in the same cycle. Characters without a region
  // still need the slot, which keeps the ordering trivial.
  logic fire;
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char       <= s_tdata[CHAR_W-1:0];
      in_line       <= s_tdata[CHAR_W +: LINE_BITS];
      in_line_start <= s_tuser[0];
      in_doc_start  <= s_tuser[1];
    end
  end

  // The scanner decides whether a brace counts; it ignores braces inside
  // quoted strings and after a double slash on the same line.
  brd_event_t ev;

  brd_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_code (in_char),
    .line_start(in_line_start),
    .doc_start (in_doc_start),
    .ev        (ev)
  );

  // The stack matches opens with closes and reports multi-line regions.
  logic                 res_valid;
  logic [LINE_BITS-1:0] res_start;

  brd_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .ev       (ev),
    .doc_start(in_doc_start),
    .line     (in_line),
    .res_valid(res_valid),
    .res_start(res_start)
  );

  // Result register. It holds a region until the downstream side takes it,
  // while the input side keeps accepting as long as it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      m_tdata <= {in_line, res_start};
    end
  end

  property p_result_registered;
    @(posedge clk) disable iff (rst) (fire && res_valid) |=> m_tvalid;
  endproperty
  a_result_registered: assert property (p_result_registered)
    else $error("region lost between stack and result register");

  property p_no_overwrite;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |-> !fire;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("processing step fired over a pending result");

  property p_held_char_stays;
    @(posedge clk) disable iff (rst) (in_valid && !fire) |=> in_valid;
  endproperty
  a_held_char_stays: assert property (p_held_char_stays)
    else $error("held character dropped without processing");

endmodule
